@@ sv/rtst_pkg.sv @@
// shared types and constants of the record table
`timescale 1ns / 1ps
package rtst_pkg;
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_MODIFY = 3'd1;
	localparam logic [2:0] OP_DELETE = 3'd2;
	localparam logic [2:0] OP_LOOKUP = 3'd3;
	localparam logic [2:0] OP_LIST = 3'd4;
	localparam logic [2:0] OP_SORT_CODE = 3'd5;
	localparam logic [2:0] OP_SORT_DESC = 3'd6;

	localparam logic [2:0] ST_DONE = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_LISTED = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	typedef struct packed {
		logic signed [31:0] code;
		logic [63:0] desc;
		logic [31:0] abbr;
		logic [7:0] stc;
	} rec_t;

	localparam int REC_W = $bits(rec_t);
endpackage

@@ sv/rtst_ram.sv @@
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module rtst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ sv/record_table_with_exchange_sort.sv @@
// Record table of up to TABLE_DEPTH records held in one ram, with insert, modify, delete,
// lookup, list and exchange sort. One item is taken at a time. Insert appends the record,
// or reports a full table; modify, lookup and list read each stored record in turn
// through the registered ram read, delete scans up to the match and closes the gap after
// it, and a sort does one compare and optional swap per cycle through the single write
// port, followed by a list. A result waits in an output register; results are held back
// while the output stalls.
`timescale 1ns / 1ps
module record_table_with_exchange_sort import rtst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] opcode,
	input logic descending,
	input logic signed [31:0] record_code,
	input logic [63:0] description_key,
	input logic [31:0] abbreviation,
	input logic [7:0] status_char,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] result_status,
	output logic signed [31:0] out_code,
	output logic [63:0] out_description,
	output logic [31:0] out_abbreviation,
	output logic [7:0] out_status_char,
	output logic last
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INS = 4'd1;
	localparam logic [3:0] S_RD = 4'd2;
	localparam logic [3:0] S_CHK = 4'd3;
	localparam logic [3:0] S_DRD = 4'd4;
	localparam logic [3:0] S_DWR = 4'd5;
	localparam logic [3:0] S_SI = 4'd6;
	localparam logic [3:0] S_SL = 4'd7;
	localparam logic [3:0] S_SC = 4'd8;
	localparam logic [3:0] S_SW = 4'd9;
	localparam logic [3:0] S_FIN = 4'd10;

	logic [3:0] state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] i_q, i_d;
	logic [2:0] op_q, op_d;
	logic dir_q, dir_d;
	rec_t key_q, key_d;
	rec_t cur_q, cur_d;
	rec_t pend_q, pend_d;
	logic [2:0] pend_st_q, pend_st_d;
	logic pend_valid_q, pend_valid_d;

	logic out_valid_q, out_valid_d;
	rec_t out_rec_q, out_rec_d;
	logic [2:0] out_st_q, out_st_d;
	logic out_last_q, out_last_d;

	logic we;
	logic [IDX_W-1:0] waddr, raddr;
	rec_t wdata;
	logic [REC_W-1:0] rdata_raw;
	rec_t rec;

	logic out_free, is_list, hit, sw;
	logic [CNT_W-1:0] idx_inc, i_inc;

	assign rec = rec_t'(rdata_raw);
	assign out_free = !out_valid_q || !out_stall;
	assign is_list = (op_q == OP_LIST) || (op_q == OP_SORT_CODE) || (op_q == OP_SORT_DESC);
	assign hit = is_list || (rec.code == key_q.code);
	assign idx_inc = idx_q + CNT_W'(1);
	assign i_inc = i_q + CNT_W'(1);

	// swap decision of the exchange sort, cur holds slot i
	always_comb begin
		if (op_q == OP_SORT_DESC) begin
			sw = dir_q ? (rec.desc > cur_q.desc) : (cur_q.desc > rec.desc);
		end else begin
			sw = dir_q ? (rec.code > cur_q.code) : (cur_q.code > rec.code);
		end
	end

	// read address per state
	always_comb begin
		case (state_q)
			S_SC: raddr = idx_inc[IDX_W-1:0];
			S_SL: raddr = i_inc[IDX_W-1:0];
			S_DRD: raddr = idx_inc[IDX_W-1:0];
			S_SI: raddr = i_q[IDX_W-1:0];
			default: raddr = idx_q[IDX_W-1:0];
		endcase
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		idx_d = idx_q;
		i_d = i_q;
		op_d = op_q;
		dir_d = dir_q;
		key_d = key_q;
		cur_d = cur_q;
		pend_d = pend_q;
		pend_st_d = pend_st_q;
		pend_valid_d = pend_valid_q;
		out_valid_d = out_valid_q && out_stall;
		out_rec_d = out_rec_q;
		out_st_d = out_st_q;
		out_last_d = out_last_q;
		we = 1'b0;
		waddr = idx_q[IDX_W-1:0];
		wdata = cur_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d = opcode;
					dir_d = descending;
					key_d.code = record_code;
					key_d.desc = description_key;
					key_d.abbr = abbreviation;
					key_d.stc = status_char;
					idx_d = '0;
					i_d = '0;
					pend_valid_d = 1'b0;
					case (opcode)
						OP_INSERT: state_d = S_INS;
						OP_MODIFY, OP_DELETE, OP_LOOKUP, OP_LIST: begin
							state_d = (count_q == '0) ? S_FIN : S_RD;
						end
						OP_SORT_CODE, OP_SORT_DESC: begin
							if (count_q == '0) begin
								state_d = S_FIN;
							end else if (count_q == CNT_W'(1)) begin
								state_d = S_RD;
							end else begin
								state_d = S_SI;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INS: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_last_d = 1'b1;
					if (count_q == CNT_W'(TABLE_DEPTH)) begin
						out_st_d = ST_FULL;
						out_rec_d = '0;
					end else begin
						out_st_d = ST_DONE;
						out_rec_d = key_q;
						we = 1'b1;
						waddr = count_q[IDX_W-1:0];
						wdata = key_q;
						count_d = count_q + CNT_W'(1);
					end
					state_d = S_IDLE;
				end
			end
			S_RD: state_d = S_CHK;
			// one record of a scan
			S_CHK: begin
				if (hit && op_q == OP_DELETE) begin
					pend_d = rec;
					pend_st_d = ST_DONE;
					pend_valid_d = 1'b1;
					state_d = S_DRD;
				end else if (hit && pend_valid_q && !out_free) begin
					state_d = S_CHK;
				end else begin
					if (hit) begin
						if (pend_valid_q) begin
							out_valid_d = 1'b1;
							out_rec_d = pend_q;
							out_st_d = pend_st_q;
							out_last_d = 1'b0;
						end
						pend_d = rec;
						pend_st_d = (op_q == OP_MODIFY) ? ST_DONE : ST_LISTED;
						pend_valid_d = 1'b1;
						if (op_q == OP_MODIFY) begin
							we = 1'b1;
							wdata = key_q;
							wdata.code = rec.code;
						end
					end
					if (idx_inc < count_q) begin
						idx_d = idx_inc;
						state_d = S_RD;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			// close the gap after a delete
			S_DRD: begin
				if (idx_inc < count_q) begin
					state_d = S_DWR;
				end else begin
					count_d = count_q - CNT_W'(1);
					state_d = S_FIN;
				end
			end
			S_DWR: begin
				we = 1'b1;
				wdata = rec;
				idx_d = idx_inc;
				state_d = S_DRD;
			end
			S_SI: state_d = S_SL;
			S_SL: begin
				cur_d = rec;
				idx_d = i_inc;
				state_d = S_SC;
			end
			// compare slot i with slot j, swap through the held record
			S_SC: begin
				if (sw) begin
					we = 1'b1;
					wdata = cur_q;
					cur_d = rec;
				end
				if (idx_inc < count_q) begin
					idx_d = idx_inc;
				end else begin
					state_d = S_SW;
				end
			end
			S_SW: begin
				we = 1'b1;
				waddr = i_q[IDX_W-1:0];
				wdata = cur_q;
				i_d = i_inc;
				if (i_inc + CNT_W'(1) < count_q) begin
					state_d = S_SI;
				end else begin
					idx_d = '0;
					state_d = S_RD;
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_last_d = 1'b1;
					if (pend_valid_q) begin
						out_rec_d = pend_q;
						out_st_d = pend_st_q;
					end else begin
						out_rec_d = '0;
						out_st_d = is_list ? ST_EMPTY : ST_NOT_FOUND;
					end
					pend_valid_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_valid_q <= pend_valid_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		i_q <= i_d;
		op_q <= op_d;
		dir_q <= dir_d;
		key_q <= key_d;
		cur_q <= cur_d;
		pend_q <= pend_d;
		pend_st_q <= pend_st_d;
		out_rec_q <= out_rec_d;
		out_st_q <= out_st_d;
		out_last_q <= out_last_d;
	end

	rtst_ram #(
		.WIDTH(REC_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign result_status = out_st_q;
	assign out_code = out_rec_q.code;
	assign out_description = out_rec_q.desc;
	assign out_abbreviation = out_rec_q.abbr;
	assign out_status_char = out_rec_q.stc;
	assign last = out_last_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_valid_q)
		else $error("held result left over in idle");
	a_sort_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SC && we) |-> waddr != raddr)
		else $error("sort write hits the read slot");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !out_free) |=> state_q == S_FIN)
		else $error("final result dropped under stall");
endmodule

@@ tb/record_table_checker.sv @@
// checker for the record table: predicts results per accepted item and compares them
`timescale 1ns / 1ps
module record_table_checker import rtst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [2:0] opcode,
	input logic descending,
	input logic signed [31:0] record_code,
	input logic [63:0] description_key,
	input logic [31:0] abbreviation,
	input logic [7:0] status_char,
	input logic out_valid,
	input logic out_stall,
	input logic [2:0] result_status,
	input logic signed [31:0] out_code,
	input logic [63:0] out_description,
	input logic [31:0] out_abbreviation,
	input logic [7:0] out_status_char,
	input logic last,
	output int fail_count,
	output int pending_results
);
	typedef struct packed {
		logic [2:0] st;
		rec_t rec;
		logic lst;
	} report_t;

	rec_t table_rec[TABLE_DEPTH];
	int table_len;
	report_t expected_reports[$];

	assign pending_results = expected_reports.size();

	function automatic bit key_above(bit by_desc, rec_t a, rec_t b);
		if (by_desc)
			return a.desc > b.desc;
		return a.code > b.code;
	endfunction

	// append the whole table as listed entries, or an empty marker
	task automatic report_table();
		report_t r;
		if (table_len == 0) begin
			r = '0;
			r.st = ST_EMPTY;
			expected_reports.push_back(r);
		end
		for (int i = 0; i < table_len; i++) begin
			r = '0;
			r.st = ST_LISTED;
			r.rec = table_rec[i];
			expected_reports.push_back(r);
		end
	endtask

	// work out the results of one item and update the table copy
	task automatic predict_item(logic [2:0] op, logic dir, rec_t in_rec);
		report_t r;
		rec_t t;
		int first;
		bit hit;
		first = expected_reports.size();
		hit = 0;
		case (op)
			OP_INSERT: begin
				r = '0;
				if (table_len >= TABLE_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					table_rec[table_len] = in_rec;
					table_len++;
					r.st = ST_DONE;
					r.rec = in_rec;
				end
				expected_reports.push_back(r);
			end
			OP_MODIFY, OP_LOOKUP: begin
				for (int i = 0; i < table_len; i++) begin
					if (table_rec[i].code == in_rec.code) begin
						r = '0;
						r.st = (op == OP_MODIFY) ? ST_DONE : ST_LISTED;
						r.rec = table_rec[i];
						expected_reports.push_back(r);
						if (op == OP_MODIFY) begin
							table_rec[i].desc = in_rec.desc;
							table_rec[i].abbr = in_rec.abbr;
							table_rec[i].stc = in_rec.stc;
						end
					end
				end
			end
			OP_DELETE: begin
				for (int i = 0; i < table_len && !hit; i++) begin
					if (table_rec[i].code == in_rec.code) begin
						hit = 1;
						r = '0;
						r.st = ST_DONE;
						r.rec = table_rec[i];
						expected_reports.push_back(r);
						for (int j = i; j + 1 < table_len; j++)
							table_rec[j] = table_rec[j + 1];
						table_len--;
					end
				end
			end
			OP_LIST: report_table();
			OP_SORT_CODE, OP_SORT_DESC: begin
				for (int i = 0; i + 1 < table_len; i++) begin
					for (int j = i + 1; j < table_len; j++) begin
						if (dir ? key_above(op == OP_SORT_DESC, table_rec[j], table_rec[i])
								: key_above(op == OP_SORT_DESC, table_rec[i], table_rec[j])) begin
							t = table_rec[i];
							table_rec[i] = table_rec[j];
							table_rec[j] = t;
						end
					end
				end
				report_table();
			end
			default: return;
		endcase
		if (expected_reports.size() == first) begin
			r = '0;
			r.st = ST_NOT_FOUND;
			expected_reports.push_back(r);
		end
		r = expected_reports[$];
		r.lst = 1'b1;
		expected_reports[$] = r;
	endtask

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		report_t got;
		report_t want;
		if (!arst_n) begin
			table_len = 0;
			fail_count = 0;
			expected_reports.delete();
		end else begin
			if (out_valid && !out_stall) begin
				got.st = result_status;
				got.rec = {out_code, out_description, out_abbreviation, out_status_char};
				got.lst = last;
				if (expected_reports.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: %h", got);
				end else begin
					want = expected_reports.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch: expected st=%0d code=%h desc=%h abbr=%h",
								want.st, want.rec.code, want.rec.desc, want.rec.abbr);
							$display("  expected stc=%h last=%b", want.rec.stc, want.lst);
							$display("  got st=%0d code=%h desc=%h abbr=%h stc=%h last=%b",
								got.st, got.rec.code, got.rec.desc, got.rec.abbr,
								got.rec.stc, got.lst);
						end
					end
				end
			end
			if (in_valid && !in_stall)
				predict_item(opcode, descending,
					{record_code, description_key, abbreviation, status_char});
		end
	end

	// leftover expectations are reported by the top through pending_results
endmodule

@@ tb/tb_record_table_with_exchange_sort.sv @@
// testbench top for the record table: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps
module tb_record_table_with_exchange_sort;
	import rtst_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [2:0] opcode;
	logic descending;
	logic signed [31:0] record_code;
	logic [63:0] description_key;
	logic [31:0] abbreviation;
	logic [7:0] status_char;
	logic [2:0] result_status;
	logic signed [31:0] out_code;
	logic [63:0] out_description;
	logic [31:0] out_abbreviation;
	logic [7:0] out_status_char;
	logic last;
	int fail_count, pending_results;
	int idle_cycles;
	bit long_hold;
	logic [31:0] code_pool[8];

	record_table_with_exchange_sort u_top (.*);
	record_table_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// output stall: random per result, one long hold when asked
	initial begin
		int wait_n;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				for (int i = 0; i < 400; i++) @(posedge clk);
				long_hold = 0;
			end
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
			for (int i = 0; i < wait_n; i++) @(posedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			out_stall <= 1'b1;
		end
	end

	// watchdog on accepted items and results
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_item(logic [2:0] op, logic dir, logic [31:0] code,
			logic [63:0] desc, logic [31:0] abbr, logic [7:0] stc, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 9);
		for (int i = 0; i < gap; i++) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		descending <= dir;
		record_code <= code;
		description_key <= desc;
		abbreviation <= abbr;
		status_char <= stc;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [31:0] pick_code();
		return ($urandom_range(0, 3) == 0) ? $urandom() : code_pool[$urandom_range(0, 7)];
	endfunction

	function automatic logic [63:0] rand_desc();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		logic [2:0] op;
		in_valid = 0; opcode = 0; descending = 0; record_code = 0;
		description_key = 0; abbreviation = 0; status_char = 0;
		long_hold = 0; idle_cycles = 0;
		arst_n = 0;
		foreach (code_pool[i]) code_pool[i] = $urandom();
		code_pool[0] = 32'h8000_0000;
		code_pool[1] = 32'h7fff_ffff;
		code_pool[2] = 32'h0;
		code_pool[3] = 32'hffff_ffff;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table, misses, extremes, every operation
		send_item(OP_LIST, 0, 0, 0, 0, 0, 0);
		send_item(OP_SORT_CODE, 1, 0, 0, 0, 0, 0);
		send_item(OP_LOOKUP, 0, 5, 0, 0, 0, 0);
		send_item(OP_MODIFY, 0, 5, 1, 1, 1, 0);
		send_item(OP_DELETE, 0, 5, 0, 0, 0, 0);
		send_item(OP_INSERT, 1, 32'h8000_0000, '1, '1, 8'hff, 0);
		send_item(OP_INSERT, 0, 32'h7fff_ffff, '0, '0, 8'h00, 0);
		send_item(OP_INSERT, 0, 32'h0, 64'h4142_0000_0000_0000, 32'h41, "A", 0);
		send_item(OP_INSERT, 0, 32'h7fff_ffff, 64'h8000_0000_0000_0000, 32'h49, "I", 0);
		send_item(OP_LOOKUP, 0, 32'h7fff_ffff, 0, 0, 0, 0);
		send_item(OP_MODIFY, 1, 32'h7fff_ffff, 64'h55, 32'h66, 8'h77, 0);
		send_item(OP_SORT_CODE, 0, 0, 0, 0, 0, 0);
		send_item(OP_SORT_CODE, 1, 0, 0, 0, 0, 0);
		send_item(OP_SORT_DESC, 0, 0, 0, 0, 0, 0);
		send_item(OP_SORT_DESC, 1, 0, 0, 0, 0, 0);
		send_item(OP_DELETE, 0, 32'h8000_0000, 0, 0, 0, 0);
		send_item(OP_LIST, 1, 0, 0, 0, 0, 0);
		send_item(OP_UNUSED, 1, '1, '1, '1, '1, 0);
		// fill to the top, three inserts beyond, with no gaps while output is held off
		long_hold = 1;
		while (u_checker.table_len < TABLE_DEPTH && pending_results < 70)
			send_item(OP_INSERT, 1'($urandom_range(0, 1)), pick_code(), rand_desc(),
				$urandom(), 8'($urandom_range(0, 255)), 1);
		for (int i = 0; i < 3; i++)
			send_item(OP_INSERT, 0, pick_code(), rand_desc(), $urandom(), 8'h55, 0);
		send_item(OP_SORT_DESC, 0, 0, 0, 0, 0, 0);
		// pause until everything has come
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);

		// random part: as many deletes as inserts to keep the table in mid range
		for (int n = 0; n < 170; n++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: op = OP_INSERT;
				6, 7: op = OP_MODIFY;
				8, 9, 10, 11, 12, 13: op = OP_DELETE;
				14, 15: op = OP_LOOKUP;
				16: op = OP_LIST;
				17: op = OP_SORT_CODE;
				18: op = OP_SORT_DESC;
				default: op = OP_UNUSED;
			endcase
			send_item(op, 1'($urandom_range(0, 1)), pick_code(),
				($urandom_range(0, 3) == 0) ? {32'h4142_4344, $urandom()} : rand_desc(),
				$urandom(), 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (pending_results != 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

@@ sim.f @@
sv/rtst_pkg.sv
sv/rtst_ram.sv
sv/record_table_with_exchange_sort.sv
tb/record_table_checker.sv
tb/tb_record_table_with_exchange_sort.sv
